### hdl/bracketed_list_splitter_defines.svh
// assertion macros for the bracketed list splitter
`ifndef BRACKETED_LIST_SPLITTER_DEFINES_SVH
`define BRACKETED_LIST_SPLITTER_DEFINES_SVH

`ifndef SYNTH

`define BLS_ASSERT_SAME(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed in same cycle");

`define BLS_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed in next cycle");

`else

`define BLS_ASSERT_SAME(label, clk, rst, cond, prop)
`define BLS_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

### hdl/bls_pkg.sv
package bls_pkg;

  localparam int unsigned MaxElementsDefault = 1024;
  localparam int unsigned DepthBitsDefault   = 8;

  localparam logic [7:0] CHAR_OPEN_SQ   = 8'h5B;
  localparam logic [7:0] CHAR_CLOSE_SQ  = 8'h5D;
  localparam logic [7:0] CHAR_OPEN_CU   = 8'h7B;
  localparam logic [7:0] CHAR_CLOSE_CU  = 8'h7D;
  localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
  localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] DELIM_RESET    = 8'h2C;

  localparam logic [2:0] ADDR_ITEM_DELIMITER = 3'd0;

  typedef enum logic [1:0] {
    ROLE_CONTENT = 2'd0,
    ROLE_SKIPPED = 2'd1,
    ROLE_DELIM   = 2'd2,
    ROLE_OUTER   = 2'd3
  } role_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_OPEN  = 2'd1,
    STATUS_NO_CLOSE = 2'd2,
    STATUS_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic [10:0] element_count;
    status_t     status;
    logic [9:0]  element_index;
    logic [7:0]  byte_out;
  } result_t;

  typedef struct packed {
    logic    cell_done;
    role_t   role;
    result_t data;
  } out_item_t;

  function automatic logic is_blank(input logic [7:0] b);
    is_blank = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
  endfunction

endpackage

### hdl/bracketed_list_splitter.sv
// channel  direction  tdata                                          tuser  tlast
// s_       in         byte_in                                        -      last_byte
// m_       out        byte_out, element_index, status, elem_count    role   cell_done
// cfg      apb        item_delimiter at 0x0
// one byte per cycle in while s_tready is high, one result per byte out, each result registered before m_
// the scan state updates on every input transfer, a single register stage holds the result
// a skid register takes one result while m_tready is low, then s_tready drops
// rst clears the scan state, the delimiter to ',' and both result valid flags
// the state returns to its reset values after each last byte
`include "bracketed_list_splitter_defines.svh"

module bracketed_list_splitter #(
  parameter int unsigned MAX_ELEMENTS = bls_pkg::MaxElementsDefault,
  parameter int unsigned DEPTH_BITS   = bls_pkg::DepthBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] byte_out, [17:8] element_index, [19:18] status,
                                 // [30:20] element_count, [31] zero
  output logic [1:0]  m_tuser,   // [1:0] role
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned EW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam logic [EW-1:0] ELEM_LAST = EW'(MAX_ELEMENTS - 1);
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

  logic [7:0] item_delimiter;

  logic                  first_pending, first_pending_next;
  logic                  in_quote, in_quote_next;
  logic [7:0]            open_quote, open_quote_next;
  logic [DEPTH_BITS-1:0] nest_depth, nest_depth_next;
  logic [EW-1:0]         current_element, current_element_next;
  logic                  skipping_space, skipping_space_next;
  logic                  item_has_content, item_has_content_next;
  logic                  inner_seen, inner_seen_next;
  bls_pkg::status_t      error_code, error_code_next;

  bls_pkg::role_t     res_role;
  bls_pkg::out_item_t res;
  bls_pkg::out_item_t out_reg;
  bls_pkg::out_item_t skid;
  logic               skid_valid;

  logic         s_fire;
  logic         m_fire;
  logic         cfg_write;
  logic [31:0]  idx_wide;
  logic [31:0]  count_wide;
  logic [EW:0]  count;
  logic [7:0]   b;
  logic         last;

  assign s_fire    = s_tvalid && s_tready;
  assign m_fire    = m_tvalid && m_tready;
  assign s_tready  = !skid_valid;
  assign b         = s_tdata;
  assign last      = s_tlast;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr == bls_pkg::ADDR_ITEM_DELIMITER) ? {24'd0, item_delimiter} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_delimiter <= bls_pkg::DELIM_RESET;
    end else if (cfg_write && (paddr == bls_pkg::ADDR_ITEM_DELIMITER)) begin
      item_delimiter <= pwdata[7:0];
    end
  end

  // scan state update
  always_comb begin
    first_pending_next    = first_pending;
    in_quote_next         = in_quote;
    open_quote_next       = open_quote;
    nest_depth_next       = nest_depth;
    current_element_next  = current_element;
    skipping_space_next   = skipping_space;
    item_has_content_next = item_has_content;
    inner_seen_next       = inner_seen;
    error_code_next       = error_code;
    res_role              = bls_pkg::ROLE_CONTENT;

    if (first_pending) begin
      res_role = bls_pkg::ROLE_OUTER;
      if ((b != bls_pkg::CHAR_OPEN_SQ) && (error_code == bls_pkg::STATUS_OK)) begin
        error_code_next = bls_pkg::STATUS_NO_OPEN;
      end
      first_pending_next = 1'b0;
    end else if (last) begin
      res_role = bls_pkg::ROLE_OUTER;
    end else begin
      inner_seen_next = 1'b1;
      if (skipping_space && bls_pkg::is_blank(b)) begin
        res_role = bls_pkg::ROLE_SKIPPED;
      end else begin
        skipping_space_next = 1'b0;
        if ((b == bls_pkg::CHAR_DQUOTE) || (b == bls_pkg::CHAR_SQUOTE)) begin
          if (!in_quote) begin
            in_quote_next   = 1'b1;
            open_quote_next = b;
          end else if (open_quote == b) begin
            in_quote_next   = 1'b0;
            open_quote_next = 8'd0;
          end
          item_has_content_next = 1'b1;
        end else if (!in_quote &&
                     ((b == bls_pkg::CHAR_OPEN_SQ) || (b == bls_pkg::CHAR_OPEN_CU))) begin
          if (nest_depth != DEPTH_MAX) begin
            nest_depth_next = nest_depth + 1'b1;
          end
          item_has_content_next = 1'b1;
        end else if (!in_quote &&
                     ((b == bls_pkg::CHAR_CLOSE_SQ) || (b == bls_pkg::CHAR_CLOSE_CU))) begin
          if (nest_depth != DEPTH_MIN) begin
            nest_depth_next = nest_depth - 1'b1;
          end
          item_has_content_next = 1'b1;
        end else if (!in_quote && (nest_depth == '0) && (b == item_delimiter)) begin
          res_role = bls_pkg::ROLE_DELIM;
          if (!item_has_content && (error_code == bls_pkg::STATUS_OK)) begin
            error_code_next = bls_pkg::STATUS_EMPTY;
          end
          if (current_element != ELEM_LAST) begin
            current_element_next = current_element + 1'b1;
          end
          skipping_space_next   = 1'b1;
          item_has_content_next = 1'b0;
        end else begin
          item_has_content_next = 1'b1;
        end
      end
    end
  end

  // result fields
  always_comb begin
    idx_wide   = first_pending ? 32'd0 : 32'(current_element);
    count      = inner_seen_next ? ({1'b0, current_element_next} + 1'b1) : '0;
    count_wide = 32'(count);

    res.role               = res_role;
    res.cell_done          = last;
    res.data.byte_out      = b;
    res.data.element_index = idx_wide[9:0];
    res.data.status        = bls_pkg::STATUS_OK;
    res.data.element_count = 11'd0;
    if (last) begin
      res.data.element_count = count_wide[10:0];
      if (error_code_next == bls_pkg::STATUS_NO_OPEN) begin
        res.data.status = bls_pkg::STATUS_NO_OPEN;
      end else if (b != bls_pkg::CHAR_CLOSE_SQ) begin
        res.data.status = bls_pkg::STATUS_NO_CLOSE;
      end else begin
        res.data.status = error_code_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_pending    <= 1'b1;
      in_quote         <= 1'b0;
      open_quote       <= 8'd0;
      nest_depth       <= '0;
      current_element  <= '0;
      skipping_space   <= 1'b1;
      item_has_content <= 1'b0;
      inner_seen       <= 1'b0;
      error_code       <= bls_pkg::STATUS_OK;
    end else if (s_fire) begin
      if (last) begin
        first_pending    <= 1'b1;
        in_quote         <= 1'b0;
        open_quote       <= 8'd0;
        nest_depth       <= '0;
        current_element  <= '0;
        skipping_space   <= 1'b1;
        item_has_content <= 1'b0;
        inner_seen       <= 1'b0;
        error_code       <= bls_pkg::STATUS_OK;
      end else begin
        first_pending    <= first_pending_next;
        in_quote         <= in_quote_next;
        open_quote       <= open_quote_next;
        nest_depth       <= nest_depth_next;
        current_element  <= current_element_next;
        skipping_space   <= skipping_space_next;
        item_has_content <= item_has_content_next;
        inner_seen       <= inner_seen_next;
        error_code       <= error_code_next;
      end
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (s_fire) begin
      if (!m_tvalid || m_fire) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (m_fire) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_fire) begin
        out_reg <= skid;
      end
    end else if (s_fire) begin
      if (!m_tvalid || m_fire) begin
        out_reg <= res;
      end else begin
        skid <= res;
      end
    end
  end

  assign m_tdata = {1'b0, out_reg.data};
  assign m_tuser = out_reg.role;
  assign m_tlast = out_reg.cell_done;

  `BLS_ASSERT_SAME(a_skid_behind_out, clk, rst, skid_valid, m_tvalid)
  `BLS_ASSERT_SAME(a_delim_never_last, clk, rst, m_tvalid && (m_tuser == bls_pkg::ROLE_DELIM), !m_tlast)
  `BLS_ASSERT_SAME(a_summary_only_done, clk, rst, m_tvalid && !m_tlast, m_tdata[30:18] == 13'd0)
  `BLS_ASSERT_NEXT(a_cell_clears, clk, rst, s_fire && s_tlast, first_pending && (current_element == '0) && (nest_depth == '0) && !inner_seen)

endmodule
